### rtl/lzssd_pkg.sv
// ----------------------------------------------------------------------------
// lzssd_pkg
// Shared types and constants of the LZSS stream decompressor.
// ----------------------------------------------------------------------------
package lzssd_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned SIZE_W     = 32;
   localparam int unsigned OFFSET_W   = 12;
   localparam int unsigned LEN_W      = 5;
   localparam int unsigned KIND_W     = 2;
   localparam int unsigned FIDX_W     = 4;
   localparam int unsigned CNT_W      = 2;

   localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20;
   localparam logic [LEN_W-1:0]  LEN_BIAS   = 5'd3;
   localparam logic [FIDX_W-1:0] FLAG_COUNT = 4'd8;
   localparam logic [CNT_W-1:0]  CHK_LAST   = 2'd3;

   localparam logic [KIND_W-1:0] KIND_DATA     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CHK_GOOD = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CHK_BAD  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ZERO_OFF = 2'd3;

   typedef enum logic [5:0] {
      PH_FLAG      = 6'b000001,
      PH_TOKEN     = 6'b000010,
      PH_PAIR_HIGH = 6'b000100,
      PH_CHECKSUM  = 6'b001000,
      PH_DONE      = 6'b010000,
      PH_COPY      = 6'b100000
   } phase_type;

endpackage

### rtl/lzssd_ram.sv
// ----------------------------------------------------------------------------
// lzssd_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lzssd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/lzss_stream_decompressor.sv
// ----------------------------------------------------------------------------
// lzss_stream_decompressor
// LZSS decoder with a 4096-byte history and a trailing 32-bit checksum.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries compressed bytes, one per request; req_tuser set marks the
//   first byte of a frame and clears the decoder state (history is kept).
//   rsp_* returns results: data bytes (rsp_tuser = 0), a checksum verdict
//   (1 good, 2 mismatch) or a zero offset error (3). rsp_tlast marks the
//   final result caused by one request.
//   csr_* writes the expected output size; write it only while idle.
// Flow:
//   A literal gives its byte in the next cycle. A pair high byte starts the
//   copy engine, which blocks requests while it copies 3 to 18 bytes and
//   reads the history RAM once per output byte.
// Reset: decoder state and the size register clear; history content is
//   undefined but is never read before this frame writes it.
// Stall: a low rsp_tready with a result pending freezes the copy engine and
//   blocks new requests; the result register holds until taken.
// ----------------------------------------------------------------------------
module lzss_stream_decompressor #(
   parameter int unsigned WINDOW_SIZE = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [lzssd_pkg::BYTE_W-1:0]  req_tdata,   // [7:0] in_byte
   input  logic                          req_tuser,   // [0] new_frame
   // result channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [lzssd_pkg::BYTE_W-1:0]  rsp_tdata,   // [7:0] out_byte
   output logic [lzssd_pkg::KIND_W-1:0]  rsp_tuser,   // [1:0] kind
   output logic                          rsp_tlast,   // last
   // configuration
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lzssd_pkg::SIZE_W-1:0]  csr_data     // expected_size
);

   import lzssd_pkg::*;

   localparam int unsigned PTR_W = $clog2(WINDOW_SIZE);

   // registers
   phase_type           phase_ff,      phase_in;
   logic [PTR_W-1:0]    wp_ff,         wp_in;
   logic [SIZE_W-1:0]   pc_ff,         pc_in;
   logic [BYTE_W-1:0]   flag_bits_ff,  flag_bits_in;
   logic [FIDX_W-1:0]   fidx_ff,       fidx_in;
   logic [BYTE_W-1:0]   pair_low_ff,   pair_low_in;
   logic [SIZE_W-1:0]   sum_u_ff,      sum_u_in;
   logic [SIZE_W-1:0]   sum_s_ff,      sum_s_in;
   logic [SIZE_W-1:0]   chk_shift_ff,  chk_shift_in;
   logic [CNT_W-1:0]    chk_cnt_ff,    chk_cnt_in;
   logic [SIZE_W-1:0]   exp_size_ff;
   logic [OFFSET_W-1:0] off_ff,        off_in;
   logic [LEN_W-1:0]    remain_ff,     remain_in;
   logic [PTR_W-1:0]    rd_addr_ff,    rd_addr_in;
   logic                fwd_ff,        fwd_in;
   logic [BYTE_W-1:0]   fwd_data_ff;
   logic                rsp_valid_ff,  rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_data_ff;
   logic [KIND_W-1:0]   rsp_kind_ff;
   logic                rsp_last_ff;

   // effective state after an optional frame clear
   phase_type           eff_phase;
   logic [PTR_W-1:0]    eff_wp;
   logic [SIZE_W-1:0]   eff_pc;
   logic [BYTE_W-1:0]   eff_flag_bits;
   logic [FIDX_W-1:0]   eff_fidx;
   logic [SIZE_W-1:0]   eff_sum_u;
   logic [SIZE_W-1:0]   eff_sum_s;
   logic [SIZE_W-1:0]   eff_chk_shift;
   logic [CNT_W-1:0]    eff_chk_cnt;

   logic                out_free;
   logic                accept;
   logic                frame_clr;
   phase_type           ph;
   logic                emit;
   logic                emit_literal;
   logic                emit_copy_end;
   logic [BYTE_W-1:0]   emit_val;
   logic                emit_stop;
   logic [OFFSET_W-1:0] pair_off;
   logic                res_load;
   logic [KIND_W-1:0]   res_kind;
   logic [BYTE_W-1:0]   res_data;
   logic                res_last;
   logic                ram_we;
   logic [BYTE_W-1:0]   ram_q;
   logic [BYTE_W-1:0]   hist_byte;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (phase_ff != PH_COPY) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign frame_clr  = accept && req_tuser;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign hist_byte = fwd_ff ? fwd_data_ff : ram_q;
   assign pair_off  = {req_tdata[7:4], pair_low_ff};

   always_comb begin
      if (frame_clr) begin
         eff_phase     = PH_FLAG;
         eff_wp        = '0;
         eff_pc        = '0;
         eff_flag_bits = '0;
         eff_fidx      = FLAG_COUNT;
         eff_sum_u     = '0;
         eff_sum_s     = '0;
         eff_chk_shift = '0;
         eff_chk_cnt   = '0;
      end else begin
         eff_phase     = phase_ff;
         eff_wp        = wp_ff;
         eff_pc        = pc_ff;
         eff_flag_bits = flag_bits_ff;
         eff_fidx      = fidx_ff;
         eff_sum_u     = sum_u_ff;
         eff_sum_s     = sum_s_ff;
         eff_chk_shift = chk_shift_ff;
         eff_chk_cnt   = chk_cnt_ff;
      end
   end

   always_comb begin
      phase_in      = eff_phase;
      wp_in         = eff_wp;
      pc_in         = eff_pc;
      flag_bits_in  = eff_flag_bits;
      fidx_in       = eff_fidx;
      pair_low_in   = pair_low_ff;
      sum_u_in      = eff_sum_u;
      sum_s_in      = eff_sum_s;
      chk_shift_in  = eff_chk_shift;
      chk_cnt_in    = eff_chk_cnt;
      off_in        = off_ff;
      remain_in     = remain_ff;
      rd_addr_in    = rd_addr_ff;
      ph            = eff_phase;
      emit          = 1'b0;
      emit_literal  = 1'b0;
      emit_copy_end = 1'b0;
      emit_val      = '0;
      emit_stop     = 1'b0;
      res_load      = 1'b0;
      res_kind      = KIND_DATA;
      res_data      = '0;
      res_last      = 1'b0;
      ram_we        = 1'b0;

      if (accept) begin
         // size reached: remaining input is the checksum
         if ((eff_phase == PH_FLAG || eff_phase == PH_TOKEN ||
              eff_phase == PH_PAIR_HIGH) && eff_pc >= exp_size_ff) begin
            ph = PH_CHECKSUM;
         end
         unique case (ph)
            PH_FLAG: begin
               flag_bits_in = req_tdata;
               fidx_in      = '0;
               phase_in     = PH_TOKEN;
            end
            PH_TOKEN: begin
               if (eff_flag_bits[eff_fidx[2:0]]) begin
                  emit         = 1'b1;
                  emit_literal = 1'b1;
                  emit_val     = req_tdata;
               end else begin
                  pair_low_in = req_tdata;
                  phase_in    = PH_PAIR_HIGH;
               end
            end
            PH_PAIR_HIGH: begin
               if (pair_off == '0) begin
                  res_load = 1'b1;
                  res_kind = KIND_ZERO_OFF;
                  res_last = 1'b1;
                  phase_in = PH_DONE;
               end else begin
                  off_in     = pair_off;
                  remain_in  = LEN_W'(req_tdata[3:0]) + LEN_BIAS;
                  rd_addr_in = eff_wp - PTR_W'(pair_off);
                  phase_in   = PH_COPY;
               end
            end
            PH_CHECKSUM: begin
               chk_shift_in = eff_chk_shift |
                              (SIZE_W'(req_tdata) << {eff_chk_cnt, 3'b000});
               if (eff_chk_cnt == CHK_LAST) begin
                  res_load   = 1'b1;
                  res_kind   = (chk_shift_in == eff_sum_u || chk_shift_in == eff_sum_s)
                               ? KIND_CHK_GOOD : KIND_CHK_BAD;
                  res_last   = 1'b1;
                  chk_cnt_in = '0;
                  phase_in   = PH_DONE;
               end else begin
                  chk_cnt_in = eff_chk_cnt + 1'b1;
                  phase_in   = PH_CHECKSUM;
               end
            end
            PH_DONE: begin
               phase_in = PH_DONE;
            end
            PH_COPY: begin
               phase_in = PH_COPY;
            end
            default: begin
               phase_in = PH_FLAG;
            end
         endcase
      end else if (phase_ff == PH_COPY && out_free) begin
         emit          = 1'b1;
         emit_val      = ({{(SIZE_W-OFFSET_W){1'b0}}, off_ff} > pc_ff) ? SPACE_BYTE
                                                                       : hist_byte;
         emit_copy_end = (remain_ff == LEN_W'(1));
         rd_addr_in    = rd_addr_ff + 1'b1;
         remain_in     = remain_ff - 1'b1;
      end

      if (emit) begin
         ram_we    = 1'b1;
         wp_in     = eff_wp + 1'b1;
         pc_in     = eff_pc + 1'b1;
         sum_u_in  = eff_sum_u + SIZE_W'(emit_val);
         sum_s_in  = eff_sum_s + {{(SIZE_W-BYTE_W){emit_val[BYTE_W-1]}}, emit_val};
         emit_stop = (pc_in >= exp_size_ff);
         res_load  = 1'b1;
         res_kind  = KIND_DATA;
         res_data  = emit_val;
         res_last  = emit_stop || emit_literal || emit_copy_end;
         if (emit_stop) begin
            phase_in = PH_CHECKSUM;
         end else if (emit_literal || emit_copy_end) begin
            fidx_in  = eff_fidx + 1'b1;
            phase_in = (fidx_in >= FLAG_COUNT) ? PH_FLAG : PH_TOKEN;
         end
      end

      if (res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      // the RAM returns old data when read and written at one address
      fwd_in = ram_we && (eff_wp == rd_addr_in);
   end

   lzssd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (WINDOW_SIZE)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (eff_wp),
      .wr_data (emit_val),
      .rd_addr (rd_addr_in),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FLAG;
         wp_ff        <= '0;
         pc_ff        <= '0;
         flag_bits_ff <= '0;
         fidx_ff      <= FLAG_COUNT;
         sum_u_ff     <= '0;
         sum_s_ff     <= '0;
         chk_shift_ff <= '0;
         chk_cnt_ff   <= '0;
         exp_size_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         wp_ff        <= wp_in;
         pc_ff        <= pc_in;
         flag_bits_ff <= flag_bits_in;
         fidx_ff      <= fidx_in;
         sum_u_ff     <= sum_u_in;
         sum_s_ff     <= sum_s_in;
         chk_shift_ff <= chk_shift_in;
         chk_cnt_ff   <= chk_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_ff       <= fwd_in;
         if (csr_valid && csr_ready) begin
            exp_size_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pair_low_ff <= pair_low_in;
      off_ff      <= off_in;
      remain_ff   <= remain_in;
      rd_addr_ff  <= rd_addr_in;
      fwd_data_ff <= emit_val;
      if (res_load) begin
         rsp_data_ff <= res_data;
         rsp_kind_ff <= res_kind;
         rsp_last_ff <= res_last;
      end
   end

   // a verdict or an error always closes the request
   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != KIND_DATA) |-> rsp_tlast)
      else $error("status result without last");

   // the copy engine never runs with nothing left to copy
   a_copy_remaining: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_COPY) |-> (remain_ff != '0))
      else $error("copy engine with zero remaining length");

   // the last copied byte releases the request channel
   a_copy_exit: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_COPY && emit && res_last) |=> (phase_ff != PH_COPY))
      else $error("copy engine did not stop after its last byte");

endmodule
